// ===== design/sss_pkg.sv =====
// Shared types and constants of the stream statistics summary block.
package sss_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W = 17;
  localparam int SUM_W = 33;
  localparam int SQ_W = 47;
  localparam int FRAC_BITS = 8;
  localparam logic [CNT_W-1:0] MAX_SAMPLES = 17'd65536;
  localparam logic [6:0] PERCENT = 7'd100;

  localparam int DVD_W = 80;
  localparam int DVS_W = 34;
  localparam int QUO_W = 47;
  localparam logic [6:0] DIV_STEPS = 7'd80;

  typedef struct packed {
    logic [CNT_W-1:0]           count;
    logic signed [SUM_W-1:0]    sum;
    logic [SQ_W-1:0]            sq;
    logic signed [SAMPLE_W-1:0] mn;
    logic signed [SAMPLE_W-1:0] mx;
  } rec_t;

endpackage

// ===== design/sss_front.sv =====
// Front end: accumulates samples of one set and emits its record at the last sample.
module sss_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                              in_last,
  input  logic                              q_full,
  output logic                              q_push,
  output sss_pkg::rec_t                     q_rec
);

  logic [sss_pkg::CNT_W-1:0]              count_r, count_nxt;
  logic signed [sss_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [sss_pkg::SQ_W-1:0]               sq_r, sq_nxt;
  logic signed [sss_pkg::SAMPLE_W-1:0]    mn_r, mn_nxt, mx_r, mx_nxt;
  logic signed [2*sss_pkg::SAMPLE_W-1:0]  prod;
  logic                                   accept, keep;

  assign in_stall = in_last & q_full;
  assign accept = in_valid & ~in_stall;
  assign keep = (count_r != sss_pkg::MAX_SAMPLES);
  assign prod = in_sample * in_sample;

  always_comb begin
    count_nxt = count_r;
    sum_nxt = sum_r;
    sq_nxt = sq_r;
    mn_nxt = mn_r;
    mx_nxt = mx_r;
    if (keep) begin
      count_nxt = count_r + 17'd1;
      sum_nxt = sum_r + {{(sss_pkg::SUM_W-sss_pkg::SAMPLE_W){in_sample[15]}}, in_sample};
      sq_nxt = sq_r + {15'd0, prod};
      if (in_sample < mn_r) mn_nxt = in_sample;
      if (in_sample > mx_r) mx_nxt = in_sample;
    end
  end

  assign q_push = accept & in_last;
  assign q_rec = '{count: count_nxt, sum: sum_nxt, sq: sq_nxt, mn: mn_nxt, mx: mx_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      count_r <= '0;
      sum_r <= '0;
      sq_r <= '0;
      mn_r <= 16'sh7FFF;
      mx_r <= 16'sh8000;
    end else if (accept) begin
      count_r <= count_nxt;
      sum_r <= sum_nxt;
      sq_r <= sq_nxt;
      mn_r <= mn_nxt;
      mx_r <= mx_nxt;
    end
  end

endmodule

// ===== design/sss_queue.sv =====
// Two-entry queue of set records between the front and the back end.
module sss_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sss_pkg::rec_t push_rec,
  input  logic          pop,
  output sss_pkg::rec_t pop_rec,
  output logic          full,
  output logic          empty
);

  sss_pkg::rec_t mem_r [2];
  logic          wr_r, rd_r;
  logic [1:0]    cnt_r;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign pop_rec = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 1'b0;
      rd_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/sss_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module sss_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sss_pkg::DVD_W-1:0]  dividend,
  input  logic [sss_pkg::DVS_W-1:0]  divisor,
  output logic                       busy,
  output logic [sss_pkg::QUO_W-1:0]  quotient,
  output logic [sss_pkg::DVS_W-1:0]  remainder
);

  logic                       busy_r;
  logic [6:0]                 cnt_r;
  logic [sss_pkg::DVD_W-1:0]  dvd_r;
  logic [sss_pkg::DVS_W-1:0]  rem_r, dvs_r;
  logic [sss_pkg::QUO_W-1:0]  quo_r;
  logic [sss_pkg::DVS_W:0]    trial, diff;
  logic                       ge;

  assign trial = {rem_r, dvd_r[sss_pkg::DVD_W-1]};
  assign diff = trial - {1'b0, dvs_r};
  assign ge = (trial >= {1'b0, dvs_r});
  assign busy = busy_r;
  assign quotient = quo_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[sss_pkg::DVD_W-2:0], 1'b0};
      rem_r <= ge ? diff[sss_pkg::DVS_W-1:0] : trial[sss_pkg::DVS_W-1:0];
      quo_r <= {quo_r[sss_pkg::QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= sss_pkg::DIV_STEPS;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_r <= 1'b0;
    end
  end

endmodule

// ===== design/sss_back.sv =====
// Back end: turns a set record into the summary with a shared multiplier and divider and a root unit.
module sss_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sss_pkg::rec_t       q_rec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [16:0]         out_sample_count,
  output logic signed [23:0]  out_mean_q8,
  output logic [37:0]         out_variance_q8,
  output logic [22:0]         out_sigma_q8,
  output logic signed [15:0]  out_largest,
  output logic signed [15:0]  out_smallest,
  output logic [15:0]         out_spread,
  output logic signed [31:0]  out_cv_percent_q8,
  output logic                out_cv_undefined,
  output logic                out_cv_saturated
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL0  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_MUL3  = 4'd4;
  localparam logic [3:0] S_DIVV  = 4'd5;
  localparam logic [3:0] S_WAITV = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DIVM  = 4'd8;
  localparam logic [3:0] S_WAITM = 4'd9;
  localparam logic [3:0] S_MULC  = 4'd10;
  localparam logic [3:0] S_DIVC  = 4'd11;
  localparam logic [3:0] S_WAITC = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]                  state_r, state_nxt;
  sss_pkg::rec_t               rec_r;
  logic [63:0]                 nq_r, d_r;
  logic [33:0]                 n2_r;
  logic [46:0]                 v2_r;
  logic [47:0]                 rad_r;
  logic [25:0]                 srem_r;
  logic [23:0]                 root_r;
  logic [4:0]                  scnt_r;
  logic signed [23:0]          mean_r;
  logic [38:0]                 num_r;
  logic                        out_valid_r;

  logic [31:0]                 mul_a, mul_b;
  logic [63:0]                 prod;
  logic [32:0]                 sum_abs33;
  logic [31:0]                 sum_abs;
  logic [23:0]                 mean_abs;
  logic [27:0]                 srem2, strial;
  logic                        sge;
  logic                        div_start, div_busy;
  logic [sss_pkg::DVD_W-1:0]   div_dvd;
  logic [sss_pkg::DVS_W-1:0]   div_dvs, div_rem;
  logic [sss_pkg::QUO_W-1:0]   div_quo;
  logic [24:0]                 mmag;
  logic                        out_free;
  logic signed [31:0]          cv_val;
  logic                        cv_sat;

  assign sum_abs33 = rec_r.sum[32] ? (~rec_r.sum + 33'd1) : rec_r.sum;
  assign sum_abs = sum_abs33[31:0];
  assign mean_abs = mean_r[23] ? (~mean_r + 24'd1) : mean_r;
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    mul_a = {15'd0, rec_r.count};
    mul_b = rec_r.sq[31:0];
    case (state_r)
      S_MUL1: mul_b = {17'd0, rec_r.sq[46:32]};
      S_MUL2: begin
        mul_a = sum_abs;
        mul_b = sum_abs;
      end
      S_MUL3: mul_b = {15'd0, rec_r.count};
      S_MULC: begin
        mul_a = {25'd0, sss_pkg::PERCENT};
        mul_b = {8'd0, root_r};
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  assign srem2 = {srem_r, rad_r[47:46]};
  assign strial = {2'd0, root_r, 2'b01};
  assign sge = (srem2 >= strial);

  always_comb begin
    div_start = 1'b0;
    div_dvd = {d_r, 16'd0};
    div_dvs = n2_r;
    case (state_r)
      S_DIVV: div_start = 1'b1;
      S_DIVM: begin
        div_start = 1'b1;
        div_dvd = {40'd0, sum_abs, 8'd0};
        div_dvs = {17'd0, rec_r.count};
      end
      S_DIVC: begin
        div_start = 1'b1;
        div_dvd = {41'd0, num_r};
        div_dvs = {10'd0, mean_abs};
      end
      default: ;
    endcase
  end

  sss_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .busy(div_busy), .quotient(div_quo), .remainder(div_rem)
  );

  assign mmag = div_quo[24:0] + {24'd0, (div_rem != '0)};

  always_comb begin
    cv_val = '0;
    cv_sat = 1'b0;
    if (!mean_r[23]) begin
      if (div_quo > 47'h7FFFFFFF) begin
        cv_val = 32'sh7FFFFFFF;
        cv_sat = 1'b1;
      end else begin
        cv_val = div_quo[31:0];
      end
    end else begin
      if (div_quo > 47'h80000000) begin
        cv_val = 32'sh80000000;
        cv_sat = 1'b1;
      end else begin
        cv_val = ~div_quo[31:0] + 32'd1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_DIVV;
      S_DIVV: state_nxt = S_WAITV;
      S_WAITV: if (!div_busy) state_nxt = S_SQRT;
      S_SQRT: if (scnt_r == 5'd1) state_nxt = S_DIVM;
      S_DIVM: state_nxt = S_WAITM;
      S_WAITM: if (!div_busy) state_nxt = S_MULC;
      S_MULC: state_nxt = (mean_r == '0) ? S_DONE : S_DIVC;
      S_DIVC: state_nxt = S_WAITC;
      S_WAITC: if (!div_busy) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: rec_r <= q_rec;
      S_MUL0: nq_r <= prod;
      S_MUL1: nq_r <= nq_r + {prod[31:0], 32'd0};
      S_MUL2: d_r <= (nq_r >= prod) ? (nq_r - prod) : 64'd0;
      S_MUL3: n2_r <= prod[33:0];
      S_WAITV: begin
        v2_r <= div_quo;
        rad_r <= {1'b0, div_quo};
        srem_r <= '0;
        root_r <= '0;
        scnt_r <= 5'd24;
      end
      S_SQRT: begin
        rad_r <= {rad_r[45:0], 2'b00};
        srem_r <= sge ? 26'(srem2 - strial) : srem2[25:0];
        root_r <= {root_r[22:0], sge};
        scnt_r <= scnt_r - 5'd1;
      end
      S_WAITM: mean_r <= rec_r.sum[32] ? 24'(~mmag + 25'd1) : div_quo[23:0];
      S_MULC: num_r <= {prod[30:0], 8'd0};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_sample_count <= rec_r.count;
      out_mean_q8 <= mean_r;
      out_variance_q8 <= v2_r[45:8];
      out_sigma_q8 <= root_r[22:0];
      out_largest <= rec_r.mx;
      out_smallest <= rec_r.mn;
      out_spread <= 16'(rec_r.mx - rec_r.mn);
      out_cv_undefined <= (mean_r == '0);
      out_cv_percent_q8 <= (mean_r == '0) ? 32'sd0 : cv_val;
      out_cv_saturated <= (mean_r != '0) & cv_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/stream_statistics_summary.sv =====
// Top level of the stream statistics summary block.
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | sample, last
//  out_    | output    | out_valid/out_stall | count, mean, variance, sigma, max, min,
//          |           |                   | spread, cv, cv flags
//
// The front end takes one sample per cycle; it stalls a last sample only while
// the two-entry record queue is full. In the back end each summary runs from its pop to
// the result register through three 80-step serial divisions, two when the mean is zero,
// and a 24-step square root.
// Reset is synchronous and clears the accumulators, the queue and the sequencer.
// A stalled result holds in the output register while the back end waits.
module stream_statistics_summary (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_sample,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [16:0]         out_sample_count,
  output logic signed [23:0]  out_mean_q8,
  output logic [37:0]         out_variance_q8,
  output logic [22:0]         out_sigma_q8,
  output logic signed [15:0]  out_largest,
  output logic signed [15:0]  out_smallest,
  output logic [15:0]         out_spread,
  output logic signed [31:0]  out_cv_percent_q8,
  output logic                out_cv_undefined,
  output logic                out_cv_saturated
);

  logic          q_full, q_empty, q_push, q_pop;
  sss_pkg::rec_t push_rec, pop_rec;

  sss_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_sample(in_sample), .in_last(in_last), .q_full(q_full), .q_push(q_push),
    .q_rec(push_rec)
  );

  sss_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_rec(push_rec), .pop(q_pop),
    .pop_rec(pop_rec), .full(q_full), .empty(q_empty)
  );

  sss_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_rec(pop_rec), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_count(out_sample_count), .out_mean_q8(out_mean_q8),
    .out_variance_q8(out_variance_q8), .out_sigma_q8(out_sigma_q8),
    .out_largest(out_largest), .out_smallest(out_smallest), .out_spread(out_spread),
    .out_cv_percent_q8(out_cv_percent_q8), .out_cv_undefined(out_cv_undefined),
    .out_cv_saturated(out_cv_saturated)
  );

endmodule

// ===== tb/tb_stream_statistics_summary.sv =====
// Self-checking testbench for the stream statistics summary block.
module tb_stream_statistics_summary;

  typedef struct {
    logic [16:0]        count;
    logic signed [23:0] mean;
    logic [37:0]        variance;
    logic [22:0]        sigma;
    logic signed [15:0] largest;
    logic signed [15:0] smallest;
    logic [15:0]        spread;
    logic signed [31:0] cv;
    logic               undef;
    logic               sat;
  } summary_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_sample;
  logic in_last;
  logic out_valid;
  logic out_stall;
  logic [16:0] out_sample_count;
  logic signed [23:0] out_mean_q8;
  logic [37:0] out_variance_q8;
  logic [22:0] out_sigma_q8;
  logic signed [15:0] out_largest;
  logic signed [15:0] out_smallest;
  logic [15:0] out_spread;
  logic signed [31:0] out_cv_percent_q8;
  logic out_cv_undefined;
  logic out_cv_saturated;

  summary_t expected_summaries[$];
  int errors = 0;
  bit quiet = 0;
  int hold_cycles = 0;

  longint unsigned set_count;
  longint set_sum;
  longint unsigned set_squares;
  longint set_min;
  longint set_max;

  stream_statistics_summary dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void clear_set();
    set_count = 0;
    set_sum = 0;
    set_squares = 0;
    set_min = 32767;
    set_max = -32768;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic void summarize_set();
    summary_t s;
    logic [127:0] n;
    logic [127:0] n2;
    logic [127:0] sm;
    logic [127:0] d;
    logic [127:0] v2;
    longint unsigned sigma;
    longint unsigned mag;
    longint unsigned num;
    longint mean;
    longint scaled;
    n = (set_count == 0) ? 1 : set_count;
    n2 = n * n;
    sm = (set_sum < 0) ? -set_sum : set_sum;
    d = (n * set_squares >= sm * sm) ? n * set_squares - sm * sm : 0;
    v2 = (d << 16) / n2;
    sigma = floor_sqrt(v2[63:0]);
    scaled = set_sum * 256;
    if (scaled >= 0) mean = scaled / longint'(n);
    else mean = -((-scaled + longint'(n) - 1) / longint'(n));
    s.count = 17'(set_count);
    s.mean = 24'(mean);
    s.variance = 38'(v2 >> 8);
    s.sigma = 23'(sigma);
    s.largest = 16'(set_max);
    s.smallest = 16'(set_min);
    s.spread = 16'(set_max - set_min);
    s.cv = 0;
    s.undef = (mean == 0);
    s.sat = 0;
    if (mean != 0) begin
      num = (100 * sigma) << 8;
      mag = num / ((mean < 0) ? -mean : mean);
      if (mean > 0) begin
        if (mag > 64'h7FFFFFFF) begin
          mag = 64'h7FFFFFFF;
          s.sat = 1;
        end
        s.cv = 32'(mag);
      end else begin
        if (mag > 64'h80000000) begin
          mag = 64'h80000000;
          s.sat = 1;
        end
        s.cv = 32'(-mag);
      end
    end
    expected_summaries.push_back(s);
    clear_set();
  endfunction

  function automatic void absorb_sample(logic signed [15:0] v, logic lst);
    longint x;
    x = longint'(v);
    if (set_count < 65536) begin
      set_count++;
      set_sum += x;
      set_squares += x * x;
      if (x < set_min) set_min = x;
      if (x > set_max) set_max = x;
    end
    if (lst) summarize_set();
  endfunction

  task automatic send_sample(logic signed [15:0] v, logic lst);
    if (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= v;
    in_last <= lst;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    absorb_sample(v, lst);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    summary_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_summaries.size() == 0) begin
        $display("Unexpected summary transaction");
        errors++;
      end else begin
        e = expected_summaries.pop_front();
        if (out_sample_count !== e.count)
          report("count", longint'(out_sample_count), longint'(e.count));
        if (out_mean_q8 !== e.mean)
          report("mean", longint'(out_mean_q8), longint'(e.mean));
        if (out_variance_q8 !== e.variance)
          report("variance", longint'(out_variance_q8), longint'(e.variance));
        if (out_sigma_q8 !== e.sigma)
          report("sigma", longint'(out_sigma_q8), longint'(e.sigma));
        if (out_largest !== e.largest)
          report("largest", longint'(out_largest), longint'(e.largest));
        if (out_smallest !== e.smallest)
          report("smallest", longint'(out_smallest), longint'(e.smallest));
        if (out_spread !== e.spread)
          report("spread", longint'(out_spread), longint'(e.spread));
        if (out_cv_percent_q8 !== e.cv)
          report("cv", longint'(out_cv_percent_q8), longint'(e.cv));
        if (out_cv_undefined !== e.undef)
          report("cv_undefined", longint'(out_cv_undefined), longint'(e.undef));
        if (out_cv_saturated !== e.sat)
          report("cv_saturated", longint'(out_cv_saturated), longint'(e.sat));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 23);
    end
  end

  task automatic test_extremes();
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
  endtask

  task automatic test_zero_mean();
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b1);
    send_sample(16'sd0, 1'b1);
  endtask

  task automatic test_saturation(logic signed [15:0] tail);
    for (int i = 0; i < 100; i++) begin
      send_sample(16'sd32767, 1'b0);
      send_sample(-16'sd32767, 1'b0);
    end
    send_sample(tail, 1'b1);
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int i = 0; i < 40; i++) send_sample(16'($urandom), ($urandom_range(2) == 0));
    send_sample(16'($urandom), 1'b1);
  endtask

  task automatic test_random(int items);
    int len;
    int sent;
    logic signed [15:0] v;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(200, 20) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(3))
          0: v = 16'($urandom);
          1: v = 16'(int'($urandom_range(40)) - 20);
          2: v = 16'($urandom_range(1000, 0));
          default: v = ($urandom_range(1)) ? 16'sd32767 : -16'sd32768;
        endcase
        send_sample(v, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_last = 1'b0;
    out_stall = 1'b0;
    clear_set();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_zero_mean();
    test_saturation(16'sd1);
    test_saturation(-16'sd1);
    test_backpressure();
    test_random(500);
    quiet = 1;
    test_random(200);
    quiet = 0;
    test_random(350);
    in_valid <= 1'b0;
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
